/* hdl/wts_pkg.sv */
// windowed track speed: shared constants and payload types
// no dependencies

package wts_pkg;

  localparam int WindowDepth = 1024;
  localparam int WinAw = $clog2(WindowDepth);
  localparam int CountW = WinAw + 1;
  localparam int FrameW = 31;
  localparam int PosW = 16;
  localparam int SpeedW = 24;
  localparam int SumW = SpeedW + CountW;
  localparam int RegW = 16;
  localparam int RegIdxW = 1;

  localparam logic [RegIdxW-1:0] RegScale = 1'b0;
  localparam logic [RegIdxW-1:0] RegRate = 1'b1;

  localparam logic [RegW-1:0] ScaleReset = 16'd256;
  localparam logic [SpeedW-1:0] SpeedMax = {SpeedW{1'b1}};

  typedef struct packed {
    logic [FrameW-1:0] frame_number;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic point_lost;
  } in_beat_t;

  typedef struct packed {
    logic [FrameW-1:0] out_frame;
    logic [SpeedW-1:0] smoothed_speed;
  } out_beat_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [SpeedW-1:0] speed;
  } win_entry_t;

  // control from the sequencer to the shared divider
  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

/* hdl/wts_if.sv */
// windowed track speed: valid/ready channel interface
// depends on wts_pkg

interface wts_in_if;
  logic valid;
  logic ready;
  wts_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wts_out_if;
  logic valid;
  logic ready;
  wts_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/wts_ram.sv */
// windowed track speed: single-port window memory, registered read
// depends on wts_pkg

module wts_ram (
  input  logic clk,
  input  logic we,
  input  logic [wts_pkg::WinAw-1:0] addr,
  input  wts_pkg::win_entry_t wdata,
  output wts_pkg::win_entry_t rdata
);

  wts_pkg::win_entry_t mem [wts_pkg::WindowDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/wts_div.sv */
// windowed track speed: radix-2 restoring divider, one bit per cycle
// depends on wts_pkg

module wts_div (
  input  logic clk,
  input  logic rst,
  input  wts_pkg::div_req_t req,
  output wts_pkg::div_rsp_t rsp
);

  logic [63:0] quo;
  logic [63:0] den;
  logic [63:0] rem;
  logic [6:0] cnt;
  logic busy;
  logic done;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem[62:0], quo[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo;

endmodule

/* hdl/windowed_track_speed.sv */
// windowed track speed: top level, sequencer around window memory, sqrt and divider
// depends on wts_pkg, wts_if, wts_ram, wts_div
//
// One tracked point is taken per beat and gives at most one result beat. A lost point
// gives no beat and the block is ready again the next cycle; a first point or a point
// that does not advance the frame has its result in the output register the cycle after
// it is taken. A moving point goes through the square root, the multiply, the speed
// division (skipped when the frame rate is zero), a drop of the oldest entry when the
// window is full, the push, a check of each window entry for pruning (every pruned
// entry plus the last check) and the mean division. The window lives in a single-port
// memory of one read or write a cycle; no clearing pass is needed since the fill count
// guards every read. The next point is taken once the previous result beat has left or
// leaves in the same cycle.

module windowed_track_speed (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [wts_pkg::RegIdxW-1:0] cfg_index,
  input  logic [wts_pkg::RegW-1:0] cfg_data,
  wts_in_if.sink in_ch,
  wts_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_MUL1, S_MUL2, S_SDIV, S_DROP, S_PUSH, S_PRD, S_PWAIT,
    S_PCHK, S_MDIV, S_OUT
  } state_t;

  state_t state;
  logic [wts_pkg::RegW-1:0] scale;
  logic [wts_pkg::RegW-1:0] rate;
  logic have_prev;
  logic [wts_pkg::PosW-1:0] prev_x;
  logic [wts_pkg::PosW-1:0] prev_y;
  logic [wts_pkg::FrameW-1:0] prev_frame;
  logic [wts_pkg::WinAw-1:0] head;
  logic [wts_pkg::CountW-1:0] count;
  logic [wts_pkg::SumW-1:0] sum;

  wts_pkg::in_beat_t cur;
  logic [wts_pkg::FrameW-1:0] gap;
  logic [41:0] sq_v;
  logic [41:0] sq_r;
  logic [40:0] sq_b;
  logic [36:0] prod;
  logic [52:0] prod2;
  logic [wts_pkg::SpeedW-1:0] speed;
  logic [9:0] span;
  logic out_valid;
  wts_pkg::out_beat_t out_data;

  logic ram_we;
  logic [wts_pkg::WinAw-1:0] ram_addr;
  wts_pkg::win_entry_t ram_wdata;
  wts_pkg::win_entry_t ram_rdata;
  wts_pkg::div_req_t dreq;
  wts_pkg::div_rsp_t drsp;

  logic [16:0] dxa;
  logic [16:0] dya;
  logic [33:0] d2;
  logic [42:0] sq_sum;
  logic [32:0] pdiff;
  logic [wts_pkg::WinAw-1:0] tail;
  logic [wts_pkg::RegW-1:0] sc_eff;
  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  assign dxa = {1'b0, in_ch.data.pos_x} - {1'b0, prev_x};
  assign dya = {1'b0, in_ch.data.pos_y} - {1'b0, prev_y};
  assign sc_eff = (scale == '0) ? wts_pkg::ScaleReset : scale;
  assign sq_sum = {1'b0, sq_r} + {2'b0, sq_b};
  assign pdiff = {2'b0, cur.frame_number} - {2'b0, ram_rdata.frame};
  assign tail = head + count[wts_pkg::WinAw-1:0];
  assign prod2 = {16'd0, prod} * {37'd0, rate};

  always_comb begin
    logic [16:0] ax;
    logic [16:0] ay;
    ax = dxa[16] ? (~dxa + 17'd1) : dxa;
    ay = dya[16] ? (~dya + 17'd1) : dya;
    d2 = ({17'd0, ax} * {17'd0, ax}) + ({17'd0, ay} * {17'd0, ay});
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = head;
    ram_wdata.frame = cur.frame_number;
    ram_wdata.speed = speed;
    if (state == S_PUSH) begin
      ram_we = 1'b1;
      ram_addr = tail;
    end
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = {11'd0, prod2};
    dreq.den = {17'd0, gap, 16'd0};
    if (state == S_MUL2) begin
      dreq.start = (rate != '0);
    end else if (state == S_PCHK && !(count != '0 && $signed(pdiff) > $signed({23'd0, span}))) begin
      dreq.start = 1'b1;
      dreq.num = {{(64-wts_pkg::SumW){1'b0}}, sum};
      dreq.den = {{(64-wts_pkg::CountW){1'b0}}, count};
    end
  end

  wts_ram u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  wts_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scale <= wts_pkg::ScaleReset;
      rate <= '0;
      have_prev <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      prev_frame <= '0;
      head <= '0;
      count <= '0;
      sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wts_pkg::RegScale: scale <= cfg_data;
          wts_pkg::RegRate: rate <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur <= in_ch.data;
            gap <= in_ch.data.frame_number - prev_frame;
            span <= (rate == '0) ? 10'd1 :
                    ((({1'b0, rate} + 17'd64) >> 7) == 17'd0) ? 10'd1 :
                    10'(({1'b0, rate} + 17'd64) >> 7);
            if (in_ch.data.point_lost) begin
              have_prev <= 1'b0;
              count <= '0;
              sum <= '0;
            end else if (!have_prev ||
                         ({1'b0, in_ch.data.frame_number} <= {1'b0, prev_frame})) begin
              have_prev <= 1'b1;
              prev_x <= in_ch.data.pos_x;
              prev_y <= in_ch.data.pos_y;
              prev_frame <= in_ch.data.frame_number;
              out_data.out_frame <= in_ch.data.frame_number;
              out_data.smoothed_speed <= '0;
              out_valid <= 1'b1;
            end else begin
              sq_v <= {d2, 8'd0};
              sq_r <= '0;
              sq_b <= {1'b1, 40'd0};
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if ({1'b0, sq_v} >= sq_sum) begin
            sq_v <= sq_v - sq_sum[41:0];
            sq_r <= {1'b0, sq_r[41:1]} + {1'b0, sq_b};
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          if (sq_b == 41'd1) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod <= {16'd0, sq_r[20:0]} * {21'd0, sc_eff};
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (rate == '0) begin
            speed <= (prod[36:32] != '0) ? wts_pkg::SpeedMax : prod[31:8];
            state <= (count[wts_pkg::WinAw]) ? S_DROP : S_PUSH;
          end else begin
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (drsp.done) begin
            speed <= (drsp.quo > 64'(wts_pkg::SpeedMax)) ? wts_pkg::SpeedMax :
                     drsp.quo[wts_pkg::SpeedW-1:0];
            state <= (count[wts_pkg::WinAw]) ? S_DROP : S_PUSH;
          end
        end
        S_DROP: begin
          state <= S_PWAIT;
        end
        S_PUSH: begin
          count <= count + 1'b1;
          sum <= sum + {{(wts_pkg::SumW-wts_pkg::SpeedW){1'b0}}, speed};
          state <= S_PRD;
        end
        S_PRD: state <= S_PCHK;
        S_PWAIT: begin
          sum <= sum - {{(wts_pkg::SumW-wts_pkg::SpeedW){1'b0}}, ram_rdata.speed};
          head <= head + 1'b1;
          count <= count - 1'b1;
          state <= S_PUSH;
        end
        S_PCHK: begin
          if (count != '0 && $signed(pdiff) > $signed({23'd0, span})) begin
            sum <= sum - {{(wts_pkg::SumW-wts_pkg::SpeedW){1'b0}}, ram_rdata.speed};
            head <= head + 1'b1;
            count <= count - 1'b1;
            state <= S_PRD;
          end else begin
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (drsp.done) begin
            out_data.out_frame <= cur.frame_number;
            out_data.smoothed_speed <= (drsp.quo > 64'(wts_pkg::SpeedMax)) ?
                                       wts_pkg::SpeedMax :
                                       drsp.quo[wts_pkg::SpeedW-1:0];
            out_valid <= 1'b1;
            prev_x <= cur.pos_x;
            prev_y <= cur.pos_y;
            prev_frame <= cur.frame_number;
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready)
    else $error("input taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= wts_pkg::CountW'(wts_pkg::WindowDepth))
    else $error("window overfilled");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");

endmodule
